// File: hw/rtl/calendar_date_time_adjust_macros.svh
// Assertion macros used by the top level of the calendar adjuster.
`ifndef CALENDAR_DATE_TIME_ADJUST_MACROS_SVH
`define CALENDAR_DATE_TIME_ADJUST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDTA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDTA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cdta_pkg.sv
// Types, codes and the month length table of the calendar adjuster.
package cdta_pkg;

   typedef enum logic [2:0] {
      KIND_ADD_MIN   = 3'd0,
      KIND_SUB_MIN   = 3'd1,
      KIND_NEXT_DAY  = 3'd2,
      KIND_PREV_DAY  = 3'd3,
      KIND_BACK_DAYS = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      DOP_NONE = 2'd0,
      DOP_FWD  = 2'd1,
      DOP_BACK = 2'd2
   } date_op_type;

   // Date step request passed from the time stage to the date stage.
   typedef struct packed {
      date_op_type op;
      logic [4:0]  back_amt;
      logic        floor_day;
   } date_req_type;

   localparam logic [5:0] MIN_MAX      = 6'd59;
   localparam logic [6:0] MIN_PER_HOUR = 7'd60;
   localparam logic [4:0] HOUR_MAX     = 5'd23;
   localparam logic [3:0] MONTH_MAX    = 4'd12;
   localparam logic [4:0] DAY_MAX      = 5'd31;
   localparam logic [4:0] BACK_MAX     = 5'd28;

   // Days in a month; months outside 1 to 12 count as 31 days.
   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = DAY_MAX;
      endcase
      return len;
   endfunction

endpackage

// File: hw/rtl/cdta_time.sv
// Minute and hour arithmetic, and the decode of which date step follows.
module cdta_time import cdta_pkg::*; (
   input  logic [2:0]   kind,
   input  logic [4:0]   hour,
   input  logic [5:0]   minute,
   input  logic [5:0]   amount,
   output logic [4:0]   out_hour,
   output logic [5:0]   out_minute,
   output date_req_type date_req
);

   logic [5:0] amt_sat;
   logic [5:0] min_sat;
   logic [4:0] hour_sat;
   logic [6:0] min_sum;
   logic [6:0] min_diff;
   logic       carry;
   logic       borrow;

   assign amt_sat  = (amount > MIN_MAX) ? MIN_MAX : amount;
   assign min_sat  = (minute > MIN_MAX) ? MIN_MAX : minute;
   assign hour_sat = (hour > HOUR_MAX) ? HOUR_MAX : hour;
   assign min_sum  = {1'b0, min_sat} + {1'b0, amt_sat};
   assign carry    = (min_sum >= MIN_PER_HOUR);
   assign borrow   = (min_sat < amt_sat);
   assign min_diff = borrow ? ({1'b0, min_sat} + MIN_PER_HOUR - {1'b0, amt_sat})
                            : ({1'b0, min_sat} - {1'b0, amt_sat});

   always_comb begin
      out_hour           = hour;
      out_minute         = minute;
      date_req.op        = DOP_NONE;
      date_req.back_amt  = 5'd1;
      date_req.floor_day = 1'b1;
      case (kind)
         KIND_ADD_MIN: begin
            out_hour   = hour_sat;
            out_minute = carry ? 6'(min_sum - MIN_PER_HOUR) : min_sum[5:0];
            if (carry) begin
               if (hour_sat == HOUR_MAX) begin
                  out_hour    = 5'd0;
                  date_req.op = DOP_FWD;
               end else begin
                  out_hour = hour_sat + 5'd1;
               end
            end
         end
         KIND_SUB_MIN: begin
            out_hour   = hour_sat;
            out_minute = min_diff[5:0];
            if (borrow) begin
               if (hour_sat == 5'd0) begin
                  // Borrowing past midnight steps the date back one day.
                  out_hour    = HOUR_MAX;
                  date_req.op = DOP_BACK;
               end else begin
                  out_hour = hour_sat - 5'd1;
               end
            end
         end
         KIND_NEXT_DAY: begin
            date_req.op = DOP_FWD;
         end
         KIND_PREV_DAY: begin
            date_req.op = DOP_BACK;
         end
         KIND_BACK_DAYS: begin
            date_req.op        = DOP_BACK;
            date_req.back_amt  = (amount > 6'(BACK_MAX)) ? BACK_MAX : amount[4:0];
            date_req.floor_day = 1'b0;
         end
         default: begin
            date_req.op = DOP_NONE;
         end
      endcase
   end

endmodule

// File: hw/rtl/cdta_date.sv
// Day, month and year stepping: one day forward or up to 28 days back.
module cdta_date import cdta_pkg::*; (
   input  logic [11:0]  year,
   input  logic [3:0]   month,
   input  logic [4:0]   day,
   input  date_req_type date_req,
   output logic [11:0]  out_year,
   output logic [3:0]   out_month,
   output logic [4:0]   out_day
);

   logic [4:0]  len_cur;
   logic [4:0]  len_prev;
   logic [4:0]  day_eff;
   logic [3:0]  prev_month;
   logic [11:0] prev_year;
   logic [5:0]  back_sum;

   assign len_cur = month_len(year[1:0] == 2'b00, month);

   // A one-day step back treats day zero as the first of the month.
   assign day_eff    = (date_req.floor_day && day == 5'd0) ? 5'd1 : day;
   assign prev_month = (month <= 4'd1) ? MONTH_MAX : month - 4'd1;
   assign prev_year  = (month <= 4'd1) ? year - 12'd1 : year;
   assign len_prev   = month_len(prev_year[1:0] == 2'b00, prev_month);
   assign back_sum   = {1'b0, len_prev} - {1'b0, date_req.back_amt} + {1'b0, day_eff};

   always_comb begin
      out_year  = year;
      out_month = month;
      out_day   = day;
      case (date_req.op)
         DOP_FWD: begin
            if (day >= len_cur) begin
               out_day = 5'd1;
               if (month >= MONTH_MAX) begin
                  out_month = 4'd1;
                  out_year  = year + 12'd1;
               end else begin
                  out_month = month + 4'd1;
               end
            end else begin
               out_day = day + 5'd1;
            end
         end
         DOP_BACK: begin
            if (day_eff <= date_req.back_amt) begin
               out_year  = prev_year;
               out_month = prev_month;
               out_day   = back_sum[4:0];
            end else begin
               out_day = day_eff - date_req.back_amt;
            end
         end
         default: begin
            out_day = day;
         end
      endcase
   end

endmodule

// File: hw/rtl/calendar_date_time_adjust.sv
// Top level of the calendar adjuster: input register, adjust logic, result register.
//
//   channel  | dir | tdata (low bit up)                                  | tuser
//   req_*    | in  | year[11:0] month[15:12] day[20:16] hour[25:21]      | kind[2:0]
//            |     | minute[31:26] amount[37:32], zero fill to 40 bits   |
//   rsp_*    | out | out_year[11:0] out_month[15:12] out_day[20:16]      | none
//            |     | out_hour[25:21] out_minute[31:26]                   |
//
// An accepted request is held in the input register, where the adjust logic works on it;
// the result is then loaded into the result register and offered there as a response.
// A new request is accepted every cycle while the response side keeps taking results.
// When the response is stalled, the result register and then the input register
// hold, and req_tready drops only once both are full.
// Reset empties both registers; no request is lost or repeated across a stall.
`include "calendar_date_time_adjust_macros.svh"

module calendar_date_time_adjust import cdta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // year, month, day, hour, minute, amount, zero fill
   input  logic [2:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // out_year, out_month, out_day, out_hour, out_minute
);

   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_kind_ff;
   logic [37:0] s1_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic        s2_ready;

   date_req_type date_req;
   logic [4:0]   adj_hour;
   logic [5:0]   adj_minute;
   logic [11:0]  adj_year;
   logic [3:0]   adj_month;
   logic [4:0]   adj_day;

   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_kind_ff <= req_tuser;
         s1_data_ff <= req_tdata[37:0];
      end
      if (s2_ready && s1_valid_ff) begin
         rsp_data_ff <= {adj_minute, adj_hour, adj_day, adj_month, adj_year};
      end
   end

   cdta_time u_time (
      .kind       (s1_kind_ff),
      .hour       (s1_data_ff[25:21]),
      .minute     (s1_data_ff[31:26]),
      .amount     (s1_data_ff[37:32]),
      .out_hour   (adj_hour),
      .out_minute (adj_minute),
      .date_req   (date_req)
   );

   cdta_date u_date (
      .year      (s1_data_ff[11:0]),
      .month     (s1_data_ff[15:12]),
      .day       (s1_data_ff[20:16]),
      .date_req  (date_req),
      .out_year  (adj_year),
      .out_month (adj_month),
      .out_day   (adj_day)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `CDTA_ASSERT_NEXT(a_s1_moves_to_rsp, clock, reset, s1_valid_ff && s2_ready, rsp_valid_ff, "request in the input register did not reach the result register")
   `CDTA_ASSERT_SAME(a_backpressure_full, clock, reset, !req_tready, s1_valid_ff && rsp_valid_ff && !rsp_tready, "request side stalled while the pipeline had room")
   `CDTA_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !s2_ready, s1_valid_ff && $stable(s1_kind_ff) && $stable(s1_data_ff), "input register changed while the result register was stalled")

endmodule
